// ===== rtl/core/tobc_pkg.sv =====
// Package for the timestamp-ordered block cache.
// Holds field widths, the slot entry and result types, and the scan state enum.
// No dependencies.
`timescale 1ns / 1ps

package tobc_pkg;

  // Field widths
  localparam int unsigned BlockW = 40;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 11;

  // One cache slot as stored in memory
  typedef struct packed {
    logic [BlockW-1:0] blk;
    logic [TimeW-1:0]  tim;
  } tobc_entry_t;

  // One result item
  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [BlockW-1:0] victim_block;
    logic [TimeW-1:0]  victim_time;
  } tobc_result_t;

  // Lookup engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_REPORT
  } tobc_state_e;

endpackage

// ===== rtl/core/tobc_engine.sv =====
// Lookup engine of the timestamp-ordered block cache: slot memory, scan FSM,
// fill count and victim tracking.
// Depends on tobc_pkg.
`timescale 1ns / 1ps

module tobc_engine import tobc_pkg::*; #(
  parameter int unsigned Entries = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [BlockW-1:0]     block_number_i,
  input  logic [TimeW-1:0]      access_time_i,
  input  logic [CountW-1:0]     active_i,
  output logic [CountW-1:0]     filled_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output tobc_result_t          res_o
);

  localparam int unsigned IdxW = $clog2(Entries);

  // Control state
  tobc_state_e       state_q, state_d;
  logic [CountW-1:0] filled_q, filled_d;
  logic [CountW-1:0] rd_cnt_q, rd_cnt_d;
  logic              pend_q, pend_d;
  logic              hit_q, hit_d;
  logic              found_q, found_d;

  // Payload state
  logic [BlockW-1:0] key_q, key_d;
  logic [TimeW-1:0]  tim_q, tim_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [BlockW-1:0] best_blk_q, best_blk_d;
  logic [TimeW-1:0]  best_time_q, best_time_d;
  tobc_result_t      res_q, res_d;

  // Memory ports
  tobc_entry_t       slot_mem_q [Entries];
  tobc_entry_t       rd_data_q;
  tobc_entry_t       wr_data;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;

  logic              accept;
  logic              fill;
  logic              scan_done;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign fill      = filled_q < active_i;
  assign scan_done = (rd_cnt_q == filled_q) && !pend_q;
  assign rd_addr   = IdxW'(rd_cnt_q);
  assign wr_data   = '{blk: key_q, tim: tim_q};
  assign wr_addr   = fill ? IdxW'(filled_q) : best_idx_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the FSM
  always_comb begin
    in_stall_o  = 1'b1;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o  = 1'b0;
      ST_SCAN:   rd_en       = (rd_cnt_q != filled_q);
      ST_DECIDE: wr_en       = !hit_q;
      ST_REPORT: res_valid_o = 1'b1;
      default:   in_stall_o  = 1'b1;
    endcase
  end

  // Scan datapath: compare the entry read last cycle, track the oldest slot
  always_comb begin
    filled_d    = filled_q;
    rd_cnt_d    = rd_cnt_q;
    pend_d      = rd_en;
    pend_idx_d  = rd_addr;
    hit_d       = hit_q;
    found_d     = found_q;
    key_d       = key_q;
    tim_d       = tim_q;
    best_idx_d  = best_idx_q;
    best_blk_d  = best_blk_q;
    best_time_d = best_time_q;
    res_d       = res_q;

    if (accept) begin
      key_d    = block_number_i;
      tim_d    = access_time_i;
      rd_cnt_d = '0;
      hit_d    = 1'b0;
      found_d  = 1'b0;
    end

    if (rd_en) rd_cnt_d = rd_cnt_q + CountW'(1);

    if (pend_q) begin
      if (rd_data_q.blk == key_q) hit_d = 1'b1;
      // strict compare keeps the lowest slot on equal times
      if (!found_q || (rd_data_q.tim < best_time_q)) begin
        found_d     = 1'b1;
        best_idx_d  = pend_idx_q;
        best_blk_d  = rd_data_q.blk;
        best_time_d = rd_data_q.tim;
      end
    end

    // Build the result and advance the fill count
    if (state_q == ST_DECIDE) begin
      res_d = '0;
      if (hit_q) begin
        res_d.hit = 1'b1;
      end else if (fill) begin
        filled_d = filled_q + CountW'(1);
      end else begin
        res_d.evicted      = 1'b1;
        res_d.victim_block = best_blk_q;
        res_d.victim_time  = best_time_q;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      filled_q <= '0;
      rd_cnt_q <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      filled_q <= filled_d;
      rd_cnt_q <= rd_cnt_d;
      pend_q   <= pend_d;
      hit_q    <= hit_d;
      found_q  <= found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    tim_q       <= tim_d;
    pend_idx_q  <= pend_idx_d;
    best_idx_q  <= best_idx_d;
    best_blk_q  <= best_blk_d;
    best_time_q <= best_time_d;
    res_q       <= res_d;
  end

  // Slot memory: one write and one registered read per cycle. Writes happen
  // only after the scan has ended, so no read and write of one item overlap.
  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= slot_mem_q[rd_addr];
  end

  assign filled_o = filled_q;
  assign res_o    = res_q;

`ifndef SYNTHESIS
  a_filled_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= active_i)
    else $error("fill count above active slot count");

  a_read_filled_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (rd_cnt_q < filled_q))
    else $error("read of a slot that was never filled");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_DECIDE) && !pend_q)
    else $error("slot write while a scan read is outstanding");

  a_hit_excludes_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_q.hit && res_q.evicted))
    else $error("result both hit and evicted");

  a_evict_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && !hit_q && !fill) |-> found_q)
    else $error("eviction without a scanned victim");
`endif

endmodule

// ===== rtl/core/timestamp_ordered_block_cache.sv =====
// Usage:
//   Input channel: in_valid_i / in_stall_o with block_number_i and
//   access_time_i. An item is taken at a clock edge with valid high and
//   stall low. Each item yields exactly one result item.
//   Output channel: out_valid_o / out_stall_i with hit_o, evicted_o,
//   victim_block_o and victim_time_o, held steady while stalled.
//   Configuration: cfg_wr_en_i writes cfg_wr_data_i as the active slot count;
//   zero reads as one, values above the slot count saturate, and the value
//   never drops below the number of filled slots. Write only while idle.
// Timing:
//   Every item scans the filled slots through the single read port of the
//   slot memory, one slot per cycle, at most the active count of them.
//   After the scan the engine decides, then reports the result, and is
//   free again once the output register takes it; the result reaches the
//   outputs through that register.
//   The output register lets the next item start while a result waits.
// Reset: all slots empty, active slot count at its maximum; no clearing pass.
// Stall: a stalled result holds; the engine waits with its next result
//   until the output register drains.
// Depends on tobc_pkg and tobc_engine.
`timescale 1ns / 1ps

module timestamp_ordered_block_cache import tobc_pkg::*; #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [CountW-1:0] cfg_wr_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BlockW-1:0] block_number_i,
  input  logic [TimeW-1:0]  access_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              hit_o,
  output logic              evicted_o,
  output logic [BlockW-1:0] victim_block_o,
  output logic [TimeW-1:0]  victim_time_o
);

  localparam int unsigned      CountMax  = (1 << CountW) - 1;
  localparam int unsigned      ActMaxInt = (ENTRIES > CountMax) ? CountMax : ENTRIES;
  localparam logic [CountW-1:0] ActMax   = CountW'(ActMaxInt);

  logic [CountW-1:0] active_q, active_d;
  logic [CountW-1:0] filled;
  logic [CountW-1:0] cfg_nz;
  logic [CountW-1:0] cfg_sat;
  logic              res_valid;
  logic              res_ready;
  tobc_result_t      res;
  logic              out_valid_q, out_valid_d;
  tobc_result_t      out_q, out_d;

  // Clamp the written slot count
  always_comb begin
    cfg_nz   = (cfg_wr_data_i == '0) ? CountW'(1) : cfg_wr_data_i;
    cfg_sat  = (cfg_nz > ActMax) ? ActMax : cfg_nz;
    active_d = active_q;
    if (cfg_wr_en_i) active_d = (cfg_sat < filled) ? filled : cfg_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActMax;
    end else begin
      active_q <= active_d;
    end
  end

  tobc_engine #(
    .Entries(ENTRIES)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .block_number_i,
    .access_time_i,
    .active_i    (active_q),
    .filled_o    (filled),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or draining, hold while stalled
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_q.hit;
  assign evicted_o      = out_q.evicted;
  assign victim_block_o = out_q.victim_block;
  assign victim_time_o  = out_q.victim_time;

endmodule

// ===== test/timestamp_ordered_block_cache_test.sv =====
// Self-checking testbench for timestamp_ordered_block_cache: a directed table, then phased
// random lookups, each result checked against a cache predictor kept inside this file.
// Depends on tobc_pkg and the cache RTL.
`timescale 1ns / 1ps

module timestamp_ordered_block_cache_test;
  import tobc_pkg::*;

  localparam int unsigned SLOTS         = 1024;
  localparam int unsigned LimitCycles   = 4000000;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned ItemsPerPhase = 58;
  localparam int unsigned GoneDepth     = 16;

  localparam logic [BlockW-1:0] BlkMax  = 40'hFF_FFFF_FFFF;
  localparam logic [TimeW-1:0]  TimeMax = 48'hFFFF_FFFF_FFFF;

  localparam tobc_result_t ResFill = '0;
  localparam tobc_result_t ResHit  = '{1'b1, 1'b0, 40'h0, 48'h0};

  // One directed step: optional active-slot write, then one lookup
  typedef struct packed {
    logic              cfg_en;
    logic [CountW-1:0] cfg_val;
    logic [BlockW-1:0] blk;
    logic [TimeW-1:0]  tim;
    logic              typed;
    tobc_result_t      res;
  } dir_row_t;

  localparam int unsigned NumRows = 19;
  localparam dir_row_t DirRows [NumRows] = '{
    // reset state: full slot count, empty cache
    '{1'b0, 11'd0,    40'h0,             48'h0,             1'b1, ResFill},
    '{1'b0, 11'd0,    BlkMax,            TimeMax,           1'b1, ResFill},
    '{1'b0, 11'd0,    40'h0,             48'd5,             1'b1, ResHit},
    // zero is held at the filled count, oldest slot goes
    '{1'b1, 11'd0,    40'h12345,         48'd100,           1'b1,
      '{1'b0, 1'b1, 40'h0, 48'h0}},
    '{1'b0, 11'd0,    BlkMax,            48'd7,             1'b1, ResHit},
    '{1'b0, 11'd0,    40'h55,            TimeMax,           1'b1,
      '{1'b0, 1'b1, 40'h12345, 48'd100}},
    // equal stored times: lowest slot loses
    '{1'b0, 11'd0,    40'h66,            48'd3,             1'b1,
      '{1'b0, 1'b1, 40'h55, TimeMax}},
    '{1'b1, 11'd1,    40'h77,            48'd9,             1'b1,
      '{1'b0, 1'b1, 40'h66, 48'd3}},
    // above the slot count saturates
    '{1'b1, 11'd2047, 40'hAA_AAAA_AAAA,  48'h5555_5555_5555, 1'b1, ResFill},
    '{1'b0, 11'd0,    40'h55_5555_5555,  48'hAAAA_AAAA_AAAA, 1'b1, ResFill},
    // below the filled count is held
    '{1'b1, 11'd3,    40'h1,             48'd0,             1'b1,
      '{1'b0, 1'b1, 40'h77, 48'd9}},
    '{1'b0, 11'd0,    40'h1,             48'd0,             1'b1, ResHit},
    '{1'b1, 11'd6,    40'h2,             48'd1,             1'b1, ResFill},
    '{1'b0, 11'd0,    40'h3,             48'd1,             1'b1, ResFill},
    '{1'b0, 11'd0,    40'h4,             48'd2,             1'b1,
      '{1'b0, 1'b1, 40'h1, 48'd0}},
    '{1'b0, 11'd0,    40'h5,             48'd0,             1'b1,
      '{1'b0, 1'b1, 40'h2, 48'd1}},
    '{1'b1, 11'd1024, 40'h6,             48'd0,             1'b1, ResFill},
    '{1'b0, 11'd0,    40'h5,             48'd99,            1'b0, ResFill},
    '{1'b0, 11'd0,    40'h7,             48'd0,             1'b0, ResFill}
  };

  localparam int unsigned PhaseCfg [NumPhases] = '{0, 10, 9, 16, 1500, 60, 64, 2047, 110, 1024};

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              cfg_wr_en_i    = 1'b0;
  logic [CountW-1:0] cfg_wr_data_i  = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [BlockW-1:0] block_number_i = '0;
  logic [TimeW-1:0]  access_time_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic              hit_o;
  logic              evicted_o;
  logic [BlockW-1:0] victim_block_o;
  logic [TimeW-1:0]  victim_time_o;

  // Predicted cache contents
  bit                cached_valid [SLOTS];
  logic [BlockW-1:0] cached_blk   [SLOTS];
  logic [TimeW-1:0]  cached_time  [SLOTS];
  int unsigned       filled_cnt = 0;
  int unsigned       active_cnt = SLOTS;

  // Recently evicted blocks, reused as stimulus for refills
  bit [BlockW-1:0]   gone_blks [GoneDepth];
  int unsigned       gone_ptr = 0;
  bit [TimeW-1:0]    now_ns = '0;

  tobc_result_t      pending_results [$];
  int unsigned       err_count   = 0;
  int unsigned       cycle_count = 0;
  int unsigned       rx_wait     = 0;
  bit                quiet_tx    = 1'b0;
  logic              quiet_rx    = 1'b0;

  timestamp_ordered_block_cache #(
    .ENTRIES(SLOTS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .block_number_i(block_number_i),
    .access_time_i (access_time_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .evicted_o     (evicted_o),
    .victim_block_o(victim_block_o),
    .victim_time_o (victim_time_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Clamp an active-slot write the way the cache does
  function automatic void apply_active(input logic [CountW-1:0] val);
    int unsigned n;
    n = 32'(val);
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    if (n < filled_cnt) n = filled_cnt;
    active_cnt = n;
  endfunction

  // Look up one block, update the predicted contents, return the result
  function automatic tobc_result_t cache_lookup(input logic [BlockW-1:0] blk,
                                                input logic [TimeW-1:0] tim);
    tobc_result_t res;
    int unsigned  i;
    int unsigned  oldest;
    bit           found;
    res    = '0;
    oldest = 0;
    found  = 1'b0;
    for (i = 0; i < SLOTS; i++) begin
      if (cached_valid[i] && cached_blk[i] == blk) begin
        res.hit = 1'b1;
        return res;
      end
    end
    // fill the lowest free slot while below the active count
    if (filled_cnt < active_cnt) begin
      for (i = 0; i < active_cnt; i++) begin
        if (!cached_valid[i]) begin
          cached_valid[i] = 1'b1;
          cached_blk[i]   = blk;
          cached_time[i]  = tim;
          filled_cnt++;
          return res;
        end
      end
      return res;
    end
    // evict the smallest stored time, lowest slot on ties
    for (i = 0; i < SLOTS; i++) begin
      if (cached_valid[i] && (!found || cached_time[i] < cached_time[oldest])) begin
        oldest = i;
        found  = 1'b1;
      end
    end
    if (!found) return res;
    res.evicted           = 1'b1;
    res.victim_block      = cached_blk[oldest];
    res.victim_time       = cached_time[oldest];
    cached_blk[oldest]    = blk;
    cached_time[oldest]   = tim;
    gone_blks[gone_ptr]   = res.victim_block;
    gone_ptr              = (gone_ptr + 1) % GoneDepth;
    return res;
  endfunction

  // Compare one accepted result with the oldest expectation
  function automatic void check_result();
    tobc_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result hit=%0b evicted=%0b block=%h time=%h",
               $time, hit_o, evicted_o, victim_block_o, victim_time_o);
      err_count++;
      return;
    end
    want = pending_results.pop_front();
    if (hit_o !== want.hit) begin
      $display("%0t: hit expected %0b got %0b", $time, want.hit, hit_o);
      err_count++;
    end
    if (evicted_o !== want.evicted) begin
      $display("%0t: evicted expected %0b got %0b", $time, want.evicted, evicted_o);
      err_count++;
    end
    if (victim_block_o !== want.victim_block) begin
      $display("%0t: victim_block expected %h got %h", $time, want.victim_block,
               victim_block_o);
      err_count++;
    end
    if (victim_time_o !== want.victim_time) begin
      $display("%0t: victim_time expected %h got %h", $time, want.victim_time,
               victim_time_o);
      err_count++;
    end
  endfunction

  // Take results and hold stall for a drawn number of cycles after each one
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      check_result();
      rx_wait = quiet_rx ? 0 : $urandom_range(0, 8);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait != 0);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("timestamp_ordered_block_cache regression: fail");
      $finish;
    end
  end

  // Offer one item after a drawn gap and record its expected result
  task automatic send_item(input logic [BlockW-1:0] blk, input logic [TimeW-1:0] tim,
                           input logic typed, input tobc_result_t typed_res);
    tobc_result_t predicted;
    int unsigned  gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    block_number_i <= blk;
    access_time_i  <= tim;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = cache_lookup(blk, tim);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and wait until every expected result is in
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [CountW-1:0] val);
    settle();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= val;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    apply_active(val);
  endtask

  // Mix resident blocks, refills of evicted blocks and fresh blocks
  task automatic random_item();
    logic [BlockW-1:0] blk;
    logic [TimeW-1:0]  tim;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 40 && filled_cnt != 0) blk = cached_blk[$urandom_range(0, filled_cnt - 1)];
    else if (pick < 50) blk = gone_blks[$urandom_range(0, GoneDepth - 1)];
    else if (pick < 80) blk = BlockW'($urandom_range(0, 4095));
    else blk = BlockW'({$urandom(), $urandom()});
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // advancing clock with frequent equal stamps
      now_ns = now_ns + TimeW'($urandom_range(0, 3));
      tim    = now_ns;
    end else if (pick < 85) begin
      tim = TimeW'($urandom_range(0, 15));
    end else begin
      tim = TimeW'({$urandom(), $urandom()});
    end
    send_item(blk, tim, 1'b0, '0);
  endtask

  initial begin
    int unsigned r;
    int unsigned p;
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (r = 0; r < NumRows; r++) begin
      if (DirRows[r].cfg_en) write_active(DirRows[r].cfg_val);
      send_item(DirRows[r].blk, DirRows[r].tim, DirRows[r].typed, DirRows[r].res);
    end

    // Random phases, one active-slot setting each
    for (p = 0; p < NumPhases; p++) begin
      write_active(CountW'(PhaseCfg[p]));
      quiet_tx = (p % 3 == 1);
      quiet_rx <= (p % 3 == 2);
      for (n = 0; n < ItemsPerPhase; n++) begin
        if (n == ItemsPerPhase / 2) settle();
        random_item();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (err_count == 0) begin
      $display("timestamp_ordered_block_cache regression: pass");
    end else begin
      $display("timestamp_ordered_block_cache regression: fail");
    end
    $finish;
  end

endmodule

// ===== timestamp_ordered_block_cache.f =====
rtl/core/tobc_pkg.sv
rtl/core/tobc_engine.sv
rtl/core/timestamp_ordered_block_cache.sv
test/timestamp_ordered_block_cache_test.sv
